/* sv/pwe_pkg.sv */
// Shared types and codes for the wireframe edge generator.
// No dependencies; used by primitive_to_wireframe_edges and its testbench.
package pwe_pkg;

  localparam int INDEX_WIDTH = 16;
  localparam int IDX_W       = 16;
  localparam int HIST_DEPTH  = 6;
  localparam int MAX_EDGES   = 4;
  localparam int CNT_W       = $clog2(MAX_EDGES + 1);

  localparam logic [IDX_W-1:0] IDX_MASK =
    IDX_W'((64'(1) << INDEX_WIDTH) - 64'(1));

  typedef logic [IDX_W-1:0] vidx_t;
  typedef logic [CNT_W-1:0] ecnt_t;

  typedef enum logic [1:0] {
    MODE_STRIP = 2'd0,
    MODE_FAN   = 2'd1,
    MODE_TRIS  = 2'd2,
    MODE_NONE  = 2'd3
  } draw_mode_t;

  typedef enum logic [2:0] {
    SRC_TRI    = 3'd0,
    SRC_QUADS  = 3'd1,
    SRC_QSTRIP = 3'd2,
    SRC_POLY   = 3'd3,
    SRC_OTHER  = 3'd4
  } src_prim_t;

  typedef struct packed {
    vidx_t edge_to;
    vidx_t edge_from;
  } line_t;

endpackage

/* sv/primitive_to_wireframe_edges.sv */
// Wireframe edge generator: turns a vertex index stream into line pairs.
// Depends on pwe_pkg for types, codes and the index mask.
//
// Usage:
//   in_*  : one vertex per beat. tdata = vertex_index, tuser = source
//           primitive type, tlast = last vertex of the segment.
//   out_* : one line per beat. tdata = {edge_to, edge_from}, tlast marks
//           the final line caused by one vertex.
//   cfg_* : write of the 2-bit draw mode; always ready, write only while idle.
// A vertex causes zero to four lines. Edges are worked out in the cycle the
// vertex is accepted and land in a four-entry line queue; the first line
// shows on out_* in the cycle after acceptance. The queue drains one line
// per cycle while the receiver is ready. A new vertex is accepted when the
// queue is empty or its last line leaves in that cycle.
// Reset (rst_n low, synchronous) empties the queue, clears segment position,
// first vertex and history, and sets the draw mode to none. A stalled
// receiver holds the current line and, once the queue is not about to
// empty, holds off the input side.
module primitive_to_wireframe_edges (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] vertex_index
  input  logic [2:0]  in_tuser,   // [2:0] source_primitive
  input  logic        in_tlast,   // last_in_segment
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] edge_from, [31:16] edge_to
  output logic        out_tlast,  // last_of_run
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data    // [1:0] draw_mode
);

  pwe_pkg::draw_mode_t mode_r;
  pwe_pkg::vidx_t      pos_r;
  logic [2:0]          pm6_r;   // segment position modulo 6
  pwe_pkg::vidx_t      first_r;
  pwe_pkg::vidx_t      hist_r [pwe_pkg::HIST_DEPTH];
  pwe_pkg::line_t      q_r    [pwe_pkg::MAX_EDGES];
  pwe_pkg::ecnt_t      cnt_r;

  logic                in_acc;
  logic                pop;
  pwe_pkg::vidx_t      v;
  pwe_pkg::vidx_t      first;
  logic                last;
  logic [2:0]          pm6_nxt;
  pwe_pkg::line_t      ln   [pwe_pkg::MAX_EDGES];
  pwe_pkg::ecnt_t      n;

  assign cfg_ready  = 1'b1;
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = q_r[0];
  assign out_tlast  = (cnt_r == pwe_pkg::ecnt_t'(1));
  assign pop        = out_tvalid & out_tready;
  assign in_tready  = (cnt_r == '0) || (out_tlast && out_tready);
  assign in_acc     = in_tvalid & in_tready;

  assign v     = in_tdata;
  assign last  = in_tlast;
  assign first = (pos_r == '0) ? v : first_r;

  always_comb begin
    if (last || pos_r == '1) begin
      pm6_nxt = 3'd0;
    end else if (pm6_r == 3'd5) begin
      pm6_nxt = 3'd0;
    end else begin
      pm6_nxt = pm6_r + 3'd1;
    end
  end

  always_comb begin
    logic       strip_like;
    logic       qstrip;
    logic       poly;
    pwe_pkg::vidx_t pivot;
    strip_like = 1'b0;
    qstrip     = 1'b0;
    poly       = 1'b0;
    pivot      = hist_r[1];
    n          = '0;
    for (int i = 0; i < pwe_pkg::MAX_EDGES; i++) begin
      ln[i] = '0;
    end

    unique case (mode_r)
      pwe_pkg::MODE_STRIP: begin
        strip_like = 1'b1;
      end
      pwe_pkg::MODE_FAN: begin
        case (in_tuser)
          pwe_pkg::SRC_QSTRIP: qstrip = 1'b1;
          pwe_pkg::SRC_POLY:   poly   = 1'b1;
          default: begin
            strip_like = 1'b1;
            pivot      = first;
          end
        endcase
      end
      pwe_pkg::MODE_TRIS: begin
        case (in_tuser)
          pwe_pkg::SRC_TRI: begin
            if (pm6_r == 3'd2 || pm6_r == 3'd5) begin
              ln[0] = '{edge_from: hist_r[1], edge_to: hist_r[0]};
              ln[1] = '{edge_from: hist_r[0], edge_to: v};
              ln[2] = '{edge_from: v,         edge_to: hist_r[1]};
              n     = pwe_pkg::ecnt_t'(3);
            end
          end
          pwe_pkg::SRC_QUADS: begin
            if (pos_r == pwe_pkg::vidx_t'(3) && last) begin
              ln[0] = '{edge_from: hist_r[2], edge_to: hist_r[1]};
              ln[1] = '{edge_from: hist_r[1], edge_to: hist_r[0]};
              ln[2] = '{edge_from: hist_r[0], edge_to: v};
              ln[3] = '{edge_from: v,         edge_to: hist_r[2]};
              n     = pwe_pkg::ecnt_t'(4);
            end else if (pm6_r == 3'd5) begin
              ln[0] = '{edge_from: hist_r[4], edge_to: hist_r[3]};
              ln[1] = '{edge_from: hist_r[3], edge_to: hist_r[2]};
              ln[2] = '{edge_from: hist_r[2], edge_to: v};
              ln[3] = '{edge_from: v,         edge_to: hist_r[4]};
              n     = pwe_pkg::ecnt_t'(4);
            end
          end
          pwe_pkg::SRC_QSTRIP: qstrip = 1'b1;
          pwe_pkg::SRC_POLY:   poly   = 1'b1;
          default: ;
        endcase
      end
      default: ;
    endcase

    if (strip_like) begin
      if (pos_r == pwe_pkg::vidx_t'(2)) begin
        ln[0] = '{edge_from: hist_r[1], edge_to: hist_r[0]};
        ln[1] = '{edge_from: hist_r[1], edge_to: v};
        ln[2] = '{edge_from: hist_r[0], edge_to: v};
        n     = pwe_pkg::ecnt_t'(3);
      end else if (pos_r > pwe_pkg::vidx_t'(2)) begin
        ln[0] = '{edge_from: pivot,     edge_to: v};
        ln[1] = '{edge_from: hist_r[0], edge_to: v};
        n     = pwe_pkg::ecnt_t'(2);
      end
    end

    if (qstrip && pos_r >= pwe_pkg::vidx_t'(3) && pos_r[0]) begin
      if (pos_r == pwe_pkg::vidx_t'(3)) begin
        ln[0] = '{edge_from: hist_r[2], edge_to: hist_r[1]};
        ln[1] = '{edge_from: hist_r[1], edge_to: hist_r[0]};
        ln[2] = '{edge_from: hist_r[2], edge_to: v};
        ln[3] = '{edge_from: hist_r[0], edge_to: v};
        n     = pwe_pkg::ecnt_t'(4);
      end else begin
        ln[0] = '{edge_from: hist_r[1], edge_to: hist_r[0]};
        ln[1] = '{edge_from: hist_r[2], edge_to: v};
        ln[2] = '{edge_from: hist_r[0], edge_to: v};
        n     = pwe_pkg::ecnt_t'(3);
      end
    end

    // polygon: edge from the previous vertex, plus a closing edge back to the first vertex on the segment's last vertex
    if (poly && pos_r != '0) begin
      ln[0] = '{edge_from: hist_r[0], edge_to: v};
      if (last) begin
        ln[1] = '{edge_from: v, edge_to: first};
        n     = pwe_pkg::ecnt_t'(2);
      end else begin
        n     = pwe_pkg::ecnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= pwe_pkg::MODE_NONE;
      pos_r   <= '0;
      pm6_r   <= '0;
      first_r <= '0;
      cnt_r   <= '0;
      for (int i = 0; i < pwe_pkg::HIST_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_r <= pwe_pkg::draw_mode_t'(cfg_data);
      end
      if (in_acc) begin
        if (pos_r == '0) begin
          first_r <= v;
        end
        for (int i = pwe_pkg::HIST_DEPTH - 1; i > 0; i--) begin
          hist_r[i] <= hist_r[i-1];
        end
        hist_r[0] <= v;
        pos_r     <= last ? '0 : pos_r + pwe_pkg::vidx_t'(1);
        pm6_r     <= pm6_nxt;
        cnt_r     <= n;
      end else if (pop) begin
        cnt_r <= cnt_r - pwe_pkg::ecnt_t'(1);
      end
    end
  end

  // line queue payload: load on accept, shift down on each beat out
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < pwe_pkg::MAX_EDGES; i++) begin
        q_r[i].edge_from <= ln[i].edge_from & pwe_pkg::IDX_MASK;
        q_r[i].edge_to   <= ln[i].edge_to & pwe_pkg::IDX_MASK;
      end
    end else if (pop) begin
      for (int i = 0; i < pwe_pkg::MAX_EDGES - 1; i++) begin
        q_r[i] <= q_r[i+1];
      end
    end
  end

endmodule

/* sv/pwe_checker.sv */
// Port-level checks for primitive_to_wireframe_edges, bound to the top level.
// Depends on the top level's port list only.
module pwe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);

  // stalled line must hold
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  // no new vertex while more than one line of the current one is queued
  a_no_accept_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input ready in the middle of a run");

  // empty queue always takes a vertex
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty queue");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind primitive_to_wireframe_edges pwe_checker u_pwe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

/* tb/tb_primitive_to_wireframe_edges.sv */
`timescale 1ns / 100ps
// Self-checking bench for primitive_to_wireframe_edges: random vertex streams in,
// wireframe lines out, each line checked against an in-bench edge predictor.
// Depends on pwe_pkg and the primitive_to_wireframe_edges RTL only.
module tb_primitive_to_wireframe_edges;

  typedef struct {
    pwe_pkg::vidx_t from_idx;
    pwe_pkg::vidx_t to_idx;
    logic           tl;
  } line_exp_t;

  // Scoreboard: mirrors the segment state and queues the lines each vertex owes.
  class edge_predictor;
    pwe_pkg::draw_mode_t mode;
    pwe_pkg::vidx_t      seg_pos;
    pwe_pkg::vidx_t      seg_first;
    pwe_pkg::vidx_t      hist [pwe_pkg::HIST_DEPTH];
    line_exp_t           lines_due [$];
    line_exp_t           run_q [$];
    int                  errors;

    function new();
      mode      = pwe_pkg::MODE_NONE;
      seg_pos   = '0;
      seg_first = '0;
      foreach (hist[k]) hist[k] = '0;
      errors    = 0;
    endfunction

    function void set_mode(logic [1:0] m);
      mode = pwe_pkg::draw_mode_t'(m);
    endfunction

    function int pending();
      return lines_due.size();
    endfunction

    function void add_line(pwe_pkg::vidx_t a, pwe_pkg::vidx_t b);
      line_exp_t item;
      item.from_idx = a & pwe_pkg::IDX_MASK;
      item.to_idx   = b & pwe_pkg::IDX_MASK;
      item.tl       = 1'b0;
      run_q.push_back(item);
    endfunction

    // far is the older pivot: two back for strips, the segment head for fans
    function void strip_lines(pwe_pkg::vidx_t p, pwe_pkg::vidx_t v, pwe_pkg::vidx_t far);
      if (p == 2) begin
        add_line(hist[1], hist[0]);
        add_line(hist[1], v);
        add_line(hist[0], v);
      end else if (p > 2) begin
        add_line(far, v);
        add_line(hist[0], v);
      end
    endfunction

    function void quad_strip_lines(pwe_pkg::vidx_t p, pwe_pkg::vidx_t v);
      if (p >= 3 && p[0]) begin
        if (p == 3) add_line(hist[2], hist[1]);
        add_line(hist[1], hist[0]);
        add_line(hist[2], v);
        add_line(hist[0], v);
      end
    endfunction

    function void polygon_lines(pwe_pkg::vidx_t p, pwe_pkg::vidx_t v, logic tl);
      if (p >= 1) begin
        add_line(hist[0], v);
        if (tl) add_line(v, seg_first);
      end
    endfunction

    function void note_vertex(pwe_pkg::vidx_t v, logic [2:0] src, logic tl);
      pwe_pkg::vidx_t p;
      line_exp_t      tail;
      p = seg_pos;
      if (p == 0) seg_first = v;
      run_q.delete();
      case (mode)
        pwe_pkg::MODE_STRIP: strip_lines(p, v, hist[1]);
        pwe_pkg::MODE_FAN: begin
          if (src == pwe_pkg::SRC_QSTRIP) quad_strip_lines(p, v);
          else if (src == pwe_pkg::SRC_POLY) polygon_lines(p, v, tl);
          else strip_lines(p, v, seg_first);
        end
        pwe_pkg::MODE_TRIS: begin
          if (src == pwe_pkg::SRC_TRI) begin
            if (p % 3 == 2) begin
              add_line(hist[1], hist[0]);
              add_line(hist[0], v);
              add_line(v, hist[1]);
            end
          end else if (src == pwe_pkg::SRC_QUADS) begin
            // a lone quad closes at position 3; otherwise quads come as six
            if (p == 3 && tl) begin
              add_line(hist[2], hist[1]);
              add_line(hist[1], hist[0]);
              add_line(hist[0], v);
              add_line(v, hist[2]);
            end else if (p % 6 == 5) begin
              add_line(hist[4], hist[3]);
              add_line(hist[3], hist[2]);
              add_line(hist[2], v);
              add_line(v, hist[4]);
            end
          end else if (src == pwe_pkg::SRC_QSTRIP) begin
            quad_strip_lines(p, v);
          end else if (src == pwe_pkg::SRC_POLY) begin
            polygon_lines(p, v, tl);
          end
        end
        default: ;
      endcase
      if (run_q.size() > 0) begin
        tail    = run_q.pop_back();
        tail.tl = 1'b1;
        run_q.push_back(tail);
      end
      foreach (run_q[k]) lines_due.push_back(run_q[k]);
      for (int k = pwe_pkg::HIST_DEPTH - 1; k > 0; k--) hist[k] = hist[k-1];
      hist[0] = v;
      seg_pos = tl ? pwe_pkg::vidx_t'(0) : pwe_pkg::vidx_t'(p + 1);
    endfunction

    function void check_line(pwe_pkg::vidx_t from_idx, pwe_pkg::vidx_t to_idx, logic tl);
      line_exp_t want;
      if (lines_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected line, expected none, actual from=%h to=%h last=%b",
                 $time, from_idx, to_idx, tl);
        return;
      end
      want = lines_due.pop_front();
      if (want.from_idx !== from_idx) begin
        errors++;
        $display("%0t: edge_from expected %h actual %h", $time, want.from_idx, from_idx);
      end
      if (want.to_idx !== to_idx) begin
        errors++;
        $display("%0t: edge_to expected %h actual %h", $time, want.to_idx, to_idx);
      end
      if (want.tl !== tl) begin
        errors++;
        $display("%0t: last_of_run expected %b actual %b", $time, want.tl, tl);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_data;

  edge_predictor sb = new();
  bit            gaps_on  = 1'b1;
  bit            hold_req = 1'b0;
  int            burst_left = 0;

  primitive_to_wireframe_edges u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_line(out_tdata[15:0], out_tdata[31:16], out_tlast);
  end

  // Receiver: random stall spans, plus one long hold-off to back up the input
  initial begin
    int  span;
    int  sel;
    bit  held;
    held = 1'b0;
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (80) @(posedge clk);
      end
      span = $urandom_range(4, 40);
      sel  = $urandom_range(0, 2);
      repeat (span) begin
        if (hold_req && !held) break;
        case (sel)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Leave valid high on return so back-to-back beats follow without a gap
  task automatic send_vertex(pwe_pkg::vidx_t v, logic [2:0] src, logic tl);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tuser  <= src;
    in_tlast  <= tl;
    do @(posedge clk); while (!in_tready);
    sb.note_vertex(v, src, tl);
  endtask

  task automatic send_segment(logic [2:0] src, int len);
    for (int k = 0; k < len; k++)
      send_vertex(pwe_pkg::vidx_t'($urandom), src, k == len - 1);
  endtask

  // Drain all owed lines, let a silent vertex finish, then write the mode
  task automatic write_mode(pwe_pkg::draw_mode_t m);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_mode(m);
  endtask

  initial begin
    pwe_pkg::draw_mode_t plan [8];
    logic [2:0]          src;
    int                  len;
    int                  sent;
    plan = '{pwe_pkg::MODE_STRIP, pwe_pkg::MODE_FAN, pwe_pkg::MODE_TRIS,
             pwe_pkg::MODE_NONE, pwe_pkg::MODE_TRIS, pwe_pkg::MODE_FAN,
             pwe_pkg::MODE_STRIP, pwe_pkg::MODE_TRIS};
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    in_tlast  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: index extremes, each mode and source, short and partial segments
    write_mode(pwe_pkg::MODE_STRIP);
    send_vertex(16'h0000, pwe_pkg::SRC_TRI, 1'b0);
    send_vertex(16'hFFFF, pwe_pkg::SRC_TRI, 1'b0);
    send_vertex(16'h8001, pwe_pkg::SRC_TRI, 1'b0);
    send_vertex(16'h7FFE, pwe_pkg::SRC_TRI, 1'b1);
    write_mode(pwe_pkg::MODE_FAN);
    send_segment(pwe_pkg::SRC_TRI, 4);
    send_segment(pwe_pkg::SRC_POLY, 3);
    send_segment(pwe_pkg::SRC_QSTRIP, 4);
    write_mode(pwe_pkg::MODE_TRIS);
    send_segment(pwe_pkg::SRC_TRI, 4);
    send_segment(pwe_pkg::SRC_QUADS, 4);
    send_segment(pwe_pkg::SRC_OTHER, 2);
    send_segment(pwe_pkg::SRC_POLY, 1);
    write_mode(pwe_pkg::MODE_NONE);
    send_segment(pwe_pkg::SRC_TRI, 3);

    // Random: mostly whole segments of one source, some ragged noise
    foreach (plan[ph]) begin
      write_mode(plan[ph]);
      if (ph == 0) hold_req = 1'b1;
      sent = 0;
      while (sent < 26) begin
        if ($urandom_range(0, 6) == 0) begin
          len = $urandom_range(1, 8);
          for (int k = 0; k < len; k++)
            send_vertex(pwe_pkg::vidx_t'($urandom), 3'($urandom_range(0, 7)),
                        $urandom_range(0, 3) == 0);
        end else begin
          src = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
          len = (src == pwe_pkg::SRC_QUADS && $urandom_range(0, 2) == 0) ? 4
                                                                 : $urandom_range(1, 14);
          send_segment(src, len);
        end
        sent += len;
      end
    end

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* sim.f */
sv/pwe_pkg.sv
sv/primitive_to_wireframe_edges.sv
sv/pwe_checker.sv
tb/tb_primitive_to_wireframe_edges.sv
